>>> sv/softmax_argmax_classifier_unit_macros.svh
// Assertion macros for the softmax classifier checker
`ifndef SOFTMAX_ARGMAX_CLASSIFIER_UNIT_MACROS_SVH
`define SOFTMAX_ARGMAX_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sac_pkg.sv
// Shared constants, types and the exponential table for the softmax classifier
`timescale 1ns / 1ps

package sac_pkg;

    localparam int NUM_CLASSES = 10;
    localparam int IDX_W       = $clog2(NUM_CLASSES);
    localparam int CLASS_W     = 4;
    localparam int LOGIT_W     = 8;
    localparam int EXP_W       = 17;
    localparam int SUM_W       = 21;
    localparam int PROB_W      = 16;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_W       = EXP_W + FRAC_BITS;
    // quotient never reaches 2^QUO_W since the sum is at least 1.0
    localparam int QUO_W       = PROB_W + 1;
    localparam int STEP_W      = $clog2(QUO_W);

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [SUM_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
    } div_rsp_t;

    // round(65536 * e^-k), zero from k = 12 on
    function automatic logic [EXP_W-1:0] exp_lookup(input logic [LOGIT_W-1:0] k);
        logic [EXP_W-1:0] e;
        case (k)
            8'd0:    e = 17'd65536;
            8'd1:    e = 17'd24109;
            8'd2:    e = 17'd8869;
            8'd3:    e = 17'd3263;
            8'd4:    e = 17'd1200;
            8'd5:    e = 17'd442;
            8'd6:    e = 17'd162;
            8'd7:    e = 17'd60;
            8'd8:    e = 17'd22;
            8'd9:    e = 17'd8;
            8'd10:   e = 17'd3;
            8'd11:   e = 17'd1;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

>>> sv/sac_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sac_div
    import sac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    den_reg, den_next;
    logic [QUO_W-1:0]    numlo_reg, numlo_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [SUM_W:0]      trial;
    logic                fits;

    assign trial = {rem_reg, numlo_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        numlo_next = numlo_reg;
        quo_next   = quo_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            // upper numerator bits are already below the divisor
            rem_next   = SUM_W'(req.num[NUM_W-1:QUO_W]);
            den_next   = req.den;
            numlo_next = req.num[QUO_W-1:0];
            quo_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? SUM_W'(trial - {1'b0, den_reg}) : trial[SUM_W-1:0];
            numlo_next = {numlo_reg[QUO_W-2:0], 1'b0};
            quo_next   = {quo_reg[QUO_W-2:0], fits};
            step_next  = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        numlo_reg <= numlo_next;
        quo_reg   <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> sv/softmax_argmax_classifier_unit.sv
// After the final logit, the exponential sum is formed over all 10 classes, then each result
// starts the divider, waits for its 17 quotient bits and its done flag, and is then presented.
// Throughput: one logit per cycle while loading; a frame of 10 logits is then handled class
// by class by the single bit-serial divider shared by all classes, so no new frame is taken
// until the final result of the frame has been taken.
// Reset (rst_n, asynchronous, active low) clears control state, maximum and counts.
`timescale 1ns / 1ps

module softmax_argmax_classifier_unit
    import sac_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [LOGIT_W-1:0] logit,
    input  logic                      in_valid,
    output logic                      in_stall,
    output logic [CLASS_W-1:0]        class_index,
    output logic [PROB_W-1:0]         probability,
    output logic [CLASS_W-1:0]        predicted_class,
    output logic                      last_result,
    output logic                      out_valid,
    input  logic                      out_stall
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SUM   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLASSES - 1);

    logic [2:0]                state_reg, state_next;
    logic [LOGIT_W-1:0]        logit_reg [NUM_CLASSES];
    logic signed [LOGIT_W-1:0] max_reg, max_next;
    logic [IDX_W-1:0]          max_idx_reg, max_idx_next;
    logic [IDX_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          cls_reg, cls_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic                      out_valid_reg, out_valid_next;
    logic [PROB_W-1:0]         prob_reg, prob_next;

    logic                      in_take;
    logic [EXP_W-1:0]          exp_val;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    assign in_stall = (state_reg != ST_LOAD);
    assign in_take  = in_valid && !in_stall;
    assign exp_val  = exp_lookup(LOGIT_W'(max_reg - $signed(logit_reg[cls_reg])));

    assign div_req.start = (state_reg == ST_START);
    assign div_req.num   = NUM_W'({exp_val, FRAC_BITS'(0)}) + NUM_W'(sum_reg >> 1);
    assign div_req.den   = sum_reg;

    sac_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        max_next       = max_reg;
        max_idx_next   = max_idx_reg;
        count_next     = count_reg;
        cls_next       = cls_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        prob_next      = prob_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_take)
                begin
                    if (logit > max_reg)
                    begin
                        max_next     = logit;
                        max_idx_next = count_reg;
                    end
                    if (count_reg == LAST_IDX)
                    begin
                        count_next = '0;
                        cls_next   = '0;
                        sum_next   = '0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        count_next = count_reg + IDX_W'(1);
                    end
                end
            end
            ST_SUM:
            begin
                sum_next = sum_reg + SUM_W'(exp_val);
                if (cls_reg == LAST_IDX)
                begin
                    cls_next   = '0;
                    state_next = ST_START;
                end
                else
                begin
                    cls_next = cls_reg + IDX_W'(1);
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // saturate 1.0 to the largest Q0.16 code
                    prob_next      = div_rsp.quo[QUO_W-1] ? '1 : div_rsp.quo[PROB_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (cls_reg == LAST_IDX)
                    begin
                        max_next     = {1'b1, {(LOGIT_W-1){1'b0}}};
                        max_idx_next = '0;
                        sum_next     = '0;
                        cls_next     = '0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        cls_next   = cls_reg + IDX_W'(1);
                        state_next = ST_START;
                    end
                end
            end
            default:
            begin
                state_next     = ST_LOAD;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            max_reg       <= {1'b1, {(LOGIT_W-1){1'b0}}};
            max_idx_reg   <= '0;
            count_reg     <= '0;
            cls_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            max_idx_reg   <= max_idx_next;
            count_reg     <= count_next;
            cls_reg       <= cls_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prob_reg <= prob_next;
        if (in_take)
        begin
            logit_reg[count_reg] <= logit;
        end
    end

    assign out_valid       = out_valid_reg;
    assign probability     = prob_reg;
    assign class_index     = CLASS_W'(cls_reg);
    assign predicted_class = CLASS_W'(max_idx_reg);
    assign last_result     = (cls_reg == LAST_IDX);

endmodule

>>> sv/sac_chk.sv
// Port-level checker for the softmax classifier, bound to the top level
`timescale 1ns / 1ps
`include "softmax_argmax_classifier_unit_macros.svh"

module sac_chk
    import sac_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_stall,
    input logic [CLASS_W-1:0]        class_index,
    input logic [PROB_W-1:0]         probability,
    input logic [CLASS_W-1:0]        predicted_class,
    input logic                      last_result,
    input logic                      out_valid,
    input logic                      out_stall
);

    logic out_take;

    assign out_take = out_valid && !out_stall;

    // no new request while a result is pending
    `SAC_ASSERT_IMP(a_no_in_during_out, out_valid, in_stall, "request taken during output")
    // the frame reopens right after its final result
    `SAC_ASSERT_NXT(a_reopen_after_last, out_take && last_result, !in_stall && !out_valid,
        "input not reopened after final result")
    `SAC_ASSERT_NXT(a_class_steps, out_take && !last_result,
        !out_valid && class_index == CLASS_W'($past(class_index) + CLASS_W'(1)),
        "class index did not advance by one")
    `SAC_ASSERT_NXT(a_pred_steady, out_take && !last_result,
        predicted_class == $past(predicted_class), "predicted class changed within frame")
    `SAC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(probability),
        "stalled result changed")

endmodule

bind softmax_argmax_classifier_unit sac_chk u_chk (.*);
